### rtl/core/scbp_pkg.sv
// Shared types, constants and helper functions for the size-class buffer pool.
// Depends on nothing; scbp_if and size_class_buffer_pool refer to it by scoped name.

package scbp_pkg;

   // Pool geometry
   localparam int NUM_CLASSES     = 3;
   localparam int SLOTS_PER_CLASS = 16;

   localparam int CLASS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int SLOT_W      = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
   localparam int SLOT_DEPTH  = NUM_CLASSES * SLOTS_PER_CLASS;
   localparam int SLOT_ADDR_W = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

   // Word field widths
   localparam int FUNC_W     = 2;
   localparam int SIZE_W     = 16;
   localparam int CLS_FLD_W  = 2;
   localparam int IDX_W      = 4;
   localparam int ID_W       = 32;
   localparam int STAT_W     = 3;
   localparam int CNT_W      = 5;
   localparam int TOT_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register map: sizes first, then counts, one per class for the first three
   localparam int CSR_CLASS_REGS = 3;
   localparam int CSR_SIZE_BASE  = 0;
   localparam int CSR_COUNT_BASE = 3;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK,
      STAT_FULL,
      STAT_UNKNOWN,
      STAT_OVERFLOW,
      STAT_BAD_HANDLE
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } fsm_type;

   // Per-class counter record held in the counter memory
   typedef struct packed {
      logic [CNT_W-1:0] busy;
      logic [TOT_W-1:0] allocs;
      logic [TOT_W-1:0] frees;
      logic [CNT_W-1:0] peak;
   } cnt_entry_type;

   // Per-slot record held in the slot memory
   typedef struct packed {
      logic [ID_W-1:0] owner;
      logic [ID_W-1:0] stamp;
   } slot_rec_type;

   typedef struct packed {
      status_type           status;
      logic [CLS_FLD_W-1:0] grant_class;
      logic [IDX_W-1:0]     grant_slot;
      logic [ID_W-1:0]      culprit_owner;
      logic [ID_W-1:0]      culprit_time;
      logic [CNT_W-1:0]     in_use_count;
      logic [TOT_W-1:0]     alloc_total;
      logic [TOT_W-1:0]     free_total;
      logic [CNT_W-1:0]     peak_in_use;
      logic                 near_exhausted;
   } result_type;

   function automatic logic [SIZE_W-1:0] size_reset(input int k);
      case (k)
         0:       return 16'd100;
         1:       return 16'd500;
         2:       return 16'd1000;
         default: return '0;
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] count_reset(input int k);
      case (k)
         0:       return 5'd10;
         1:       return 5'd5;
         2:       return 5'd5;
         default: return '0;
      endcase
   endfunction

   // Flat slot memory address of a class and slot
   function automatic logic [SLOT_ADDR_W-1:0] slot_addr(input logic [CLASS_W-1:0] c,
                                                        input logic [SLOT_W-1:0]  s);
      return SLOT_ADDR_W'(int'(c) * SLOTS_PER_CLASS + int'(s));
   endfunction

   // Fill the counter fields of a result from a class record
   function automatic result_type report_class(input result_type       r,
                                               input cnt_entry_type    c,
                                               input logic [CNT_W-1:0] usable);
      result_type o;
      o                = r;
      o.in_use_count   = c.busy;
      o.alloc_total    = c.allocs;
      o.free_total     = c.frees;
      o.peak_in_use    = c.peak;
      // usable - 2 <= peak, rearranged to stay unsigned
      o.near_exhausted = ({1'b0, usable} <= ({1'b0, c.peak} + (CNT_W+1)'(2)));
      return o;
   endfunction

endpackage

### rtl/core/scbp_if.sv
// Valid/ready channel interfaces for request, response and CSR write words.
// Depends on scbp_pkg for field widths.

interface scbp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [scbp_pkg::FUNC_W-1:0]          func;
   logic [scbp_pkg::SIZE_W-1:0]          req_size;
   logic [scbp_pkg::CLS_FLD_W-1:0]       slot_class;
   logic [scbp_pkg::IDX_W-1:0]           slot_index;
   logic                                 guard_intact;
   logic [scbp_pkg::ID_W-1:0]            owner_id;
   logic [scbp_pkg::ID_W-1:0]            timestamp;

   modport source (output valid, func, req_size, slot_class, slot_index, guard_intact,
                   owner_id, timestamp, input ready);
   modport sink   (input valid, func, req_size, slot_class, slot_index, guard_intact,
                   owner_id, timestamp, output ready);
endinterface

interface scbp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [scbp_pkg::STAT_W-1:0]          status;
   logic [scbp_pkg::CLS_FLD_W-1:0]       grant_class;
   logic [scbp_pkg::IDX_W-1:0]           grant_slot;
   logic [scbp_pkg::ID_W-1:0]            culprit_owner;
   logic [scbp_pkg::ID_W-1:0]            culprit_time;
   logic [scbp_pkg::CNT_W-1:0]           in_use_count;
   logic [scbp_pkg::TOT_W-1:0]           alloc_total;
   logic [scbp_pkg::TOT_W-1:0]           free_total;
   logic [scbp_pkg::CNT_W-1:0]           peak_in_use;
   logic                                 near_exhausted;

   modport source (output valid, status, grant_class, grant_slot, culprit_owner,
                   culprit_time, in_use_count, alloc_total, free_total, peak_in_use,
                   near_exhausted, input ready);
   modport sink   (input valid, status, grant_class, grant_slot, culprit_owner,
                   culprit_time, in_use_count, alloc_total, free_total, peak_in_use,
                   near_exhausted, output ready);
endinterface

interface scbp_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [scbp_pkg::CSR_IDX_W-1:0]       reg_index;
   logic [scbp_pkg::CSR_DATA_W-1:0]      wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

### rtl/core/size_class_buffer_pool.sv
// Size-class buffer pool top level. A word is accepted only in the idle state, where the counter
// and slot memories are read; in the execute state its result is loaded into the output register
// and the memories are written back. A new word is not accepted until the last one has executed,
// since the memories are read-modify-written; execute waits while an untaken result is held.
// Reset (synchronous): frees all slots, zeroes counters via per-class valid bits and restores
// class sizes and counts; no clearing pass is needed. Depends on scbp_pkg, scbp_if, scbp_ram.

module size_class_buffer_pool (
   input  logic          clock,
   input  logic          reset,
   scbp_req_if.sink      req_chan,
   scbp_rsp_if.source    rsp_chan,
   scbp_csr_if.sink      csr_chan
);

   // ---------------------------------------------------------------- declarations
   scbp_pkg::fsm_type                         state_ff, state_in;
   logic                                      req_fire, exec_fire, out_free;

   logic [scbp_pkg::SIZE_W-1:0]               size_ff  [scbp_pkg::NUM_CLASSES];
   logic [scbp_pkg::CNT_W-1:0]                count_ff [scbp_pkg::NUM_CLASSES];
   logic                                      csr_fire;

   logic [scbp_pkg::NUM_CLASSES-1:0][scbp_pkg::SLOTS_PER_CLASS-1:0] busy_ff, busy_in;
   logic [scbp_pkg::NUM_CLASSES-1:0]          cnt_valid_ff, cnt_valid_in;

   // accept-side decode
   logic                                      match_found;
   logic [scbp_pkg::CLASS_W-1:0]              match_cls;
   logic [scbp_pkg::CLASS_W-1:0]              cls_in;
   logic                                      cls_ok_in;
   logic [scbp_pkg::CNT_W-1:0]                usable_in;
   logic [scbp_pkg::SLOTS_PER_CLASS-1:0]      row, free_vec;
   logic [scbp_pkg::SLOT_W-1:0]               enc_slot, slot_in;
   logic                                      any_free, found_in, idx_in_range;

   // word held for the execute cycle
   logic [scbp_pkg::FUNC_W-1:0]               op_ff;
   logic [scbp_pkg::CLASS_W-1:0]              cls_ff;
   logic                                      cls_ok_ff;
   logic [scbp_pkg::SLOT_W-1:0]               slot_ff;
   logic                                      found_ff;
   logic                                      guard_ff;
   logic [scbp_pkg::ID_W-1:0]                 owner_ff;
   logic [scbp_pkg::ID_W-1:0]                 stamp_ff;
   logic [scbp_pkg::CNT_W-1:0]                usable_ff;

   // memories
   scbp_pkg::cnt_entry_type                   cnt_rdata, cnt_cur, cnt_new;
   scbp_pkg::slot_rec_type                    slot_rdata, slot_wdata;
   logic                                      cnt_we, slot_we, busy_set, busy_clr;

   // result
   scbp_pkg::result_type                      res, rsp_ff;
   logic                                      rsp_valid_ff, rsp_valid_in;

   // ---------------------------------------------------------------- control FSM
   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scbp_pkg::S_IDLE: begin
            if (req_fire) state_in = scbp_pkg::S_EXEC;
         end
         scbp_pkg::S_EXEC: begin
            if (exec_fire) state_in = scbp_pkg::S_IDLE;
         end
         default: state_in = scbp_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      exec_fire      = 1'b0;
      unique case (state_ff)
         scbp_pkg::S_IDLE: req_chan.ready = 1'b1;
         scbp_pkg::S_EXEC: exec_fire      = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scbp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- CSR writes
   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid;

   always_ff @(posedge clock) begin
      for (int k = 0; k < scbp_pkg::NUM_CLASSES; k++) begin
         if (reset) begin
            size_ff[k]  <= scbp_pkg::size_reset(k);
            count_ff[k] <= scbp_pkg::count_reset(k);
         end else if (csr_fire && k < scbp_pkg::CSR_CLASS_REGS) begin
            if (int'(csr_chan.reg_index) == scbp_pkg::CSR_SIZE_BASE + k) begin
               size_ff[k] <= csr_chan.wr_data;
            end
            if (int'(csr_chan.reg_index) == scbp_pkg::CSR_COUNT_BASE + k) begin
               count_ff[k] <= csr_chan.wr_data[scbp_pkg::CNT_W-1:0];
            end
         end
      end
   end

   // ---------------------------------------------------------------- accept decode
   // first class whose size matches, class zero first
   always_comb begin
      match_found = 1'b0;
      match_cls   = '0;
      for (int k = scbp_pkg::NUM_CLASSES - 1; k >= 0; k--) begin
         if (size_ff[k] == req_chan.req_size) begin
            match_found = 1'b1;
            match_cls   = scbp_pkg::CLASS_W'(k);
         end
      end
   end

   always_comb begin
      if (req_chan.func == scbp_pkg::FUNC_ALLOC) begin
         cls_in    = match_cls;
         cls_ok_in = match_found;
      end else begin
         cls_in    = req_chan.slot_class[scbp_pkg::CLASS_W-1:0];
         cls_ok_in = int'(req_chan.slot_class) < scbp_pkg::NUM_CLASSES;
      end
   end

   // usable slots of the addressed class, clamped to the slots per class
   always_comb begin
      usable_in = '0;
      row       = '0;
      if (cls_ok_in) begin
         usable_in = (int'(count_ff[cls_in]) > scbp_pkg::SLOTS_PER_CLASS) ?
                     scbp_pkg::CNT_W'(scbp_pkg::SLOTS_PER_CLASS) : count_ff[cls_in];
         row       = busy_ff[cls_in];
      end
   end

   // lowest free usable slot
   always_comb begin
      enc_slot = '0;
      any_free = 1'b0;
      for (int s = scbp_pkg::SLOTS_PER_CLASS - 1; s >= 0; s--) begin
         free_vec[s] = !row[s] && (int'(usable_in) > s);
         if (free_vec[s]) begin
            enc_slot = scbp_pkg::SLOT_W'(s);
            any_free = 1'b1;
         end
      end
   end

   // a freed slot must be within the usable range and busy
   assign idx_in_range = int'(req_chan.slot_index) < int'(usable_in);

   always_comb begin
      if (req_chan.func == scbp_pkg::FUNC_ALLOC) begin
         slot_in  = enc_slot;
         found_in = any_free;
      end else begin
         slot_in  = scbp_pkg::SLOT_W'(req_chan.slot_index);
         found_in = idx_in_range ? row[scbp_pkg::SLOT_W'(req_chan.slot_index)] : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= req_chan.func;
         cls_ff    <= cls_in;
         cls_ok_ff <= cls_ok_in;
         slot_ff   <= slot_in;
         found_ff  <= found_in;
         guard_ff  <= req_chan.guard_intact;
         owner_ff  <= req_chan.owner_id;
         stamp_ff  <= req_chan.timestamp;
         usable_ff <= usable_in;
      end
   end

   // ---------------------------------------------------------------- memories
   scbp_ram #(
      .WIDTH ($bits(scbp_pkg::cnt_entry_type)),
      .DEPTH (scbp_pkg::NUM_CLASSES)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cls_ff),
      .wr_data (cnt_new),
      .rd_en   (req_fire),
      .rd_addr (cls_in),
      .rd_data (cnt_rdata)
   );

   scbp_ram #(
      .WIDTH ($bits(scbp_pkg::slot_rec_type)),
      .DEPTH (scbp_pkg::SLOT_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (scbp_pkg::slot_addr(cls_ff, slot_ff)),
      .wr_data (slot_wdata),
      .rd_en   (req_fire),
      .rd_addr (scbp_pkg::slot_addr(cls_in, scbp_pkg::SLOT_W'(req_chan.slot_index))),
      .rd_data (slot_rdata)
   );

   assign slot_wdata = '{owner: owner_ff, stamp: stamp_ff};

   // a class record never written reads as zero
   assign cnt_cur = (cls_ok_ff && cnt_valid_ff[cls_ff]) ? cnt_rdata : '0;

   // ---------------------------------------------------------------- execute
   always_comb begin
      res      = '0;
      res.status = scbp_pkg::STAT_BAD_HANDLE;
      cnt_new  = cnt_cur;
      cnt_we   = 1'b0;
      slot_we  = 1'b0;
      busy_set = 1'b0;
      busy_clr = 1'b0;
      case (op_ff)
         scbp_pkg::FUNC_ALLOC: begin
            if (!cls_ok_ff) begin
               res.status = scbp_pkg::STAT_UNKNOWN;
            end else if (!found_ff) begin
               res.status = scbp_pkg::STAT_FULL;
               res        = scbp_pkg::report_class(res, cnt_cur, usable_ff);
            end else begin
               cnt_new.busy   = cnt_cur.busy + 1'b1;
               cnt_new.allocs = (cnt_cur.allocs == '1) ? cnt_cur.allocs
                                                        : cnt_cur.allocs + 1'b1;
               cnt_new.peak   = (cnt_new.busy > cnt_cur.peak) ? cnt_new.busy : cnt_cur.peak;
               res.status      = scbp_pkg::STAT_OK;
               res.grant_class = scbp_pkg::CLS_FLD_W'(cls_ff);
               res.grant_slot  = scbp_pkg::IDX_W'(slot_ff);
               res             = scbp_pkg::report_class(res, cnt_new, usable_ff);
               cnt_we   = 1'b1;
               slot_we  = 1'b1;
               busy_set = 1'b1;
            end
         end
         scbp_pkg::FUNC_FREE: begin
            if (!cls_ok_ff) begin
               res.status = scbp_pkg::STAT_BAD_HANDLE;
            end else if (!found_ff) begin
               res.status = scbp_pkg::STAT_BAD_HANDLE;
               res        = scbp_pkg::report_class(res, cnt_cur, usable_ff);
            end else begin
               cnt_new.busy  = (cnt_cur.busy != '0) ? cnt_cur.busy - 1'b1 : cnt_cur.busy;
               cnt_new.frees = (cnt_cur.frees == '1) ? cnt_cur.frees
                                                      : cnt_cur.frees + 1'b1;
               if (guard_ff) begin
                  res.status = scbp_pkg::STAT_OK;
               end else begin
                  res.status        = scbp_pkg::STAT_OVERFLOW;
                  res.culprit_owner = slot_rdata.owner;
                  res.culprit_time  = slot_rdata.stamp;
               end
               res      = scbp_pkg::report_class(res, cnt_new, usable_ff);
               cnt_we   = 1'b1;
               busy_clr = 1'b1;
            end
         end
         scbp_pkg::FUNC_QUERY: begin
            if (cls_ok_ff) begin
               res.status = scbp_pkg::STAT_OK;
               res        = scbp_pkg::report_class(res, cnt_cur, usable_ff);
            end
         end
         default: res.status = scbp_pkg::STAT_BAD_HANDLE;
      endcase
      // only commit when the result can be registered
      cnt_we   = cnt_we && exec_fire;
      slot_we  = slot_we && exec_fire;
      busy_set = busy_set && exec_fire;
      busy_clr = busy_clr && exec_fire;
   end

   // slot busy flags and counter valid bits
   always_comb begin
      busy_in      = busy_ff;
      cnt_valid_in = cnt_valid_ff;
      if (busy_set) busy_in[cls_ff][slot_ff] = 1'b1;
      if (busy_clr) busy_in[cls_ff][slot_ff] = 1'b0;
      if (cnt_we)   cnt_valid_in[cls_ff]     = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= '0;
         cnt_valid_ff <= '0;
      end else begin
         busy_ff      <= busy_in;
         cnt_valid_ff <= cnt_valid_in;
      end
   end

   // ---------------------------------------------------------------- output register
   always_comb begin
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_ff <= res;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_ff.status;
   assign rsp_chan.grant_class    = rsp_ff.grant_class;
   assign rsp_chan.grant_slot     = rsp_ff.grant_slot;
   assign rsp_chan.culprit_owner  = rsp_ff.culprit_owner;
   assign rsp_chan.culprit_time   = rsp_ff.culprit_time;
   assign rsp_chan.in_use_count   = rsp_ff.in_use_count;
   assign rsp_chan.alloc_total    = rsp_ff.alloc_total;
   assign rsp_chan.free_total     = rsp_ff.free_total;
   assign rsp_chan.peak_in_use    = rsp_ff.peak_in_use;
   assign rsp_chan.near_exhausted = rsp_ff.near_exhausted;

   // ---------------------------------------------------------------- assertions
   a_alloc_marks_busy: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && op_ff == scbp_pkg::FUNC_ALLOC && cls_ok_ff && found_ff)
      |=> busy_ff[cls_ff][slot_ff])
      else $error("granted slot not marked busy");

   a_free_clears_busy: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && op_ff == scbp_pkg::FUNC_FREE && cls_ok_ff && found_ff)
      |=> !busy_ff[cls_ff][slot_ff])
      else $error("freed slot still marked busy");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(exec_fire))
      else $error("response appeared without an execute cycle");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == scbp_pkg::S_EXEC)
      else $error("accepted word did not enter execute");

   a_busy_within_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.in_use_count <= rsp_ff.peak_in_use)
      else $error("in-use count above recorded peak");

endmodule

### rtl/core/scbp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.

module scbp_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### dv/tb_top.sv
// Self-checking bench for size_class_buffer_pool: a directed table of request words, then
// random allocate/free/query/undefined traffic under several class settings, scored against a pool model.
// Depends on scbp_pkg and the scbp_req_if, scbp_rsp_if and scbp_csr_if channel interfaces.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import scbp_pkg::*;

   localparam logic [FUNC_W-1:0]    FUNC_UNDEF   = 2'd3;
   localparam logic [CLS_FLD_W-1:0] CLASS_NONE   = 2'd3;
   localparam int                   CYCLE_LIMIT  = 200000;
   localparam int                   DRAIN_CYCLES = 6;
   localparam int                   PHASES       = 6;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [SIZE_W-1:0]    req_size;
      logic [CLS_FLD_W-1:0] slot_class;
      logic [IDX_W-1:0]     slot_index;
      logic                 guard_intact;
      logic [ID_W-1:0]      owner_id;
      logic [ID_W-1:0]      timestamp;
   } req_word_type;

   // one row of the directed table; typed rows carry a hand-written result
   typedef struct {
      req_word_type w;
      bit           typed;
      result_type   res;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   scbp_req_if req_bus ();
   scbp_rsp_if rsp_bus ();
   scbp_csr_if csr_bus ();

   size_class_buffer_pool u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #4ns clock = ~clock;

   // Pool model state
   logic [SIZE_W-1:0] size_cfg   [NUM_CLASSES];
   logic [CNT_W-1:0]  count_cfg  [NUM_CLASSES];
   logic              pool_busy  [NUM_CLASSES][SLOTS_PER_CLASS];
   logic [ID_W-1:0]   pool_owner [NUM_CLASSES][SLOTS_PER_CLASS];
   logic [ID_W-1:0]   pool_stamp [NUM_CLASSES][SLOTS_PER_CLASS];
   logic [CNT_W-1:0]  cls_busy   [NUM_CLASSES];
   logic [TOT_W-1:0]  cls_allocs [NUM_CLASSES];
   logic [TOT_W-1:0]  cls_frees  [NUM_CLASSES];
   logic [CNT_W-1:0]  cls_peak   [NUM_CLASSES];

   result_type expected_rsps[$];
   int         mismatches  = 0;
   int         cycle_count = 0;
   bit         quiet_run   = 1'b0;

   // Class settings per phase; row 0 is the reset setting, the last two are drawn at random
   int unsigned phase_size  [PHASES][NUM_CLASSES] = '{
      '{100, 500, 1000}, '{1, 65535, 2}, '{7, 7, 300}, '{65535, 1, 65535},
      '{0, 0, 0}, '{0, 0, 0}};
   int unsigned phase_count [PHASES][NUM_CLASSES] = '{
      '{10, 5, 5}, '{16, 16, 16}, '{0, 1, 2}, '{3, 16, 0}, '{0, 0, 0}, '{0, 0, 0}};
   int          phase_items [PHASES] = '{200, 250, 150, 150, 150, 200};

   function automatic int usable_slots(input int k);
      return (count_cfg[k] > SLOTS_PER_CLASS) ? SLOTS_PER_CLASS : int'(count_cfg[k]);
   endfunction

   function automatic result_type with_class_stats(input result_type r, input int k);
      result_type o;
      o                = r;
      o.in_use_count   = cls_busy[k];
      o.alloc_total    = cls_allocs[k];
      o.free_total     = cls_frees[k];
      o.peak_in_use    = cls_peak[k];
      // signed compare: a count below two is always near exhaustion
      o.near_exhausted = (usable_slots(k) - 2 <= int'(cls_peak[k]));
      return o;
   endfunction

   // Apply one request word to the pool model and return the result it should give
   function automatic result_type pool_predict(input req_word_type w);
      result_type r;
      int         k;
      int         s;
      int         n;
      r = '0;
      k = 0;
      s = 0;
      case (w.func)
         FUNC_ALLOC: begin
            while (k < NUM_CLASSES && size_cfg[k] != w.req_size) k++;
            if (k == NUM_CLASSES) begin
               r.status = STAT_UNKNOWN;
            end else begin
               n = usable_slots(k);
               while (s < n && pool_busy[k][s]) s++;
               if (s == n) begin
                  r.status = STAT_FULL;
               end else begin
                  pool_busy[k][s]  = 1'b1;
                  pool_owner[k][s] = w.owner_id;
                  pool_stamp[k][s] = w.timestamp;
                  cls_busy[k]++;
                  if (cls_allocs[k] != '1) cls_allocs[k]++;
                  if (cls_busy[k] > cls_peak[k]) cls_peak[k] = cls_busy[k];
                  r.status      = STAT_OK;
                  r.grant_class = CLS_FLD_W'(k);
                  r.grant_slot  = IDX_W'(s);
               end
               r = with_class_stats(r, k);
            end
         end
         FUNC_FREE: begin
            k = int'(w.slot_class);
            s = int'(w.slot_index);
            if (k >= NUM_CLASSES) begin
               r.status = STAT_BAD_HANDLE;
            end else if (s >= usable_slots(k) || !pool_busy[k][s]) begin
               r.status = STAT_BAD_HANDLE;
               r        = with_class_stats(r, k);
            end else begin
               if (w.guard_intact) begin
                  r.status = STAT_OK;
               end else begin
                  r.status        = STAT_OVERFLOW;
                  r.culprit_owner = pool_owner[k][s];
                  r.culprit_time  = pool_stamp[k][s];
               end
               pool_busy[k][s]  = 1'b0;
               pool_owner[k][s] = '0;
               pool_stamp[k][s] = '0;
               if (cls_busy[k] != 0) cls_busy[k]--;
               if (cls_frees[k] != '1) cls_frees[k]++;
               r = with_class_stats(r, k);
            end
         end
         FUNC_QUERY: begin
            k = int'(w.slot_class);
            if (k < NUM_CLASSES) begin
               r.status = STAT_OK;
               r        = with_class_stats(r, k);
            end else begin
               r.status = STAT_BAD_HANDLE;
            end
         end
         default: begin
            r.status = STAT_BAD_HANDLE;
         end
      endcase
      return r;
   endfunction

   function automatic req_word_type req_word(input logic [FUNC_W-1:0] f,
                                             input logic [SIZE_W-1:0] sz,
                                             input logic [CLS_FLD_W-1:0] c,
                                             input logic [IDX_W-1:0] i,
                                             input logic g,
                                             input logic [ID_W-1:0] o,
                                             input logic [ID_W-1:0] t);
      return '{f, sz, c, i, g, o, t};
   endfunction

   function automatic result_type pool_result(input status_type st, input int gc, input int gs,
                                              input logic [ID_W-1:0] co,
                                              input logic [ID_W-1:0] ct,
                                              input int busy, input logic [TOT_W-1:0] al,
                                              input logic [TOT_W-1:0] fr, input int pk,
                                              input bit ne);
      result_type r;
      r.status         = st;
      r.grant_class    = CLS_FLD_W'(gc);
      r.grant_slot     = IDX_W'(gs);
      r.culprit_owner  = co;
      r.culprit_time   = ct;
      r.in_use_count   = CNT_W'(busy);
      r.alloc_total    = al;
      r.free_total     = fr;
      r.peak_in_use    = CNT_W'(pk);
      r.near_exhausted = ne;
      return r;
   endfunction

   // Random request word; frees mostly name a live slot so pools fill and drain
   task automatic make_random_word(input int alloc_pct, output req_word_type w);
      int pick;
      int j;
      int live_cls[$];
      int live_slot[$];
      w.func         = FUNC_QUERY;
      w.req_size     = SIZE_W'($urandom);
      w.slot_class   = CLS_FLD_W'($urandom_range(0, 3));
      w.slot_index   = IDX_W'($urandom);
      w.guard_intact = ($urandom_range(0, 99) < 80);
      w.owner_id     = $urandom;
      w.timestamp    = $urandom;
      pick           = $urandom_range(0, 99);
      if (pick < 3) begin
         w.func = FUNC_UNDEF;
      end else if (pick < 3 + alloc_pct) begin
         w.func = FUNC_ALLOC;
         if ($urandom_range(0, 9) < 8) w.req_size = size_cfg[$urandom_range(0, NUM_CLASSES - 1)];
      end else if (pick < 90) begin
         w.func = FUNC_FREE;
         for (int k = 0; k < NUM_CLASSES; k++) begin
            for (int s = 0; s < usable_slots(k); s++) begin
               if (pool_busy[k][s]) begin
                  live_cls.push_back(k);
                  live_slot.push_back(s);
               end
            end
         end
         if (live_cls.size() != 0 && $urandom_range(0, 9) < 8) begin
            j            = $urandom_range(0, live_cls.size() - 1);
            w.slot_class = CLS_FLD_W'(live_cls[j]);
            w.slot_index = IDX_W'(live_slot[j]);
         end
      end
   endtask

   // Present one request word and, once it is taken, log what it should produce
   task automatic send_word(input req_word_type w, input bit typed, input result_type typed_res);
      int         gap;
      result_type r;
      gap = quiet_run ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.func         <= w.func;
      req_bus.req_size     <= w.req_size;
      req_bus.slot_class   <= w.slot_class;
      req_bus.slot_index   <= w.slot_index;
      req_bus.guard_intact <= w.guard_intact;
      req_bus.owner_id     <= w.owner_id;
      req_bus.timestamp    <= w.timestamp;
      do @(posedge clock); while (!req_bus.ready);
      r = pool_predict(w);
      expected_rsps.push_back(typed ? typed_res : r);
   endtask

   task automatic write_csr(input int idx, input int unsigned data);
      @(negedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= CSR_IDX_W'(idx);
      csr_bus.wr_data   <= CSR_DATA_W'(data);
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      if (idx < CSR_COUNT_BASE) size_cfg[idx - CSR_SIZE_BASE] = data[SIZE_W-1:0];
      else count_cfg[idx - CSR_COUNT_BASE] = data[CNT_W-1:0];
   endtask

   task automatic wait_drained();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [ID_W-1:0] want,
                                input logic [ID_W-1:0] seen);
      if (want !== seen) begin
         mismatches++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, seen);
      end
   endtask

   // Result checker: every accepted word against the oldest expectation
   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word, expected none, got status %0d", $time,
                     rsp_bus.status);
         end else begin
            want = expected_rsps.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_bus.status));
            compare_field("grant_class", 32'(want.grant_class), 32'(rsp_bus.grant_class));
            compare_field("grant_slot", 32'(want.grant_slot), 32'(rsp_bus.grant_slot));
            compare_field("culprit_owner", want.culprit_owner, rsp_bus.culprit_owner);
            compare_field("culprit_time", want.culprit_time, rsp_bus.culprit_time);
            compare_field("in_use_count", 32'(want.in_use_count), 32'(rsp_bus.in_use_count));
            compare_field("alloc_total", want.alloc_total, rsp_bus.alloc_total);
            compare_field("free_total", want.free_total, rsp_bus.free_total);
            compare_field("peak_in_use", 32'(want.peak_in_use), 32'(rsp_bus.peak_in_use));
            compare_field("near_exhausted", 32'(want.near_exhausted),
                          32'(rsp_bus.near_exhausted));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side back-pressure: a random stall before each word, none during quiet runs
   initial begin : rsp_stall
      int stall;
      wait (!reset);
      forever begin
         stall = quiet_run ? 0 : $urandom_range(0, 4);
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin : stimulus
      dir_row_type  rows[$];
      req_word_type w;
      int           alloc_pct;
      int           p;
      int           k;
      int           n;

      req_bus.valid        = 1'b0;
      req_bus.func         = '0;
      req_bus.req_size     = '0;
      req_bus.slot_class   = '0;
      req_bus.slot_index   = '0;
      req_bus.guard_intact = 1'b0;
      req_bus.owner_id     = '0;
      req_bus.timestamp    = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.reg_index    = '0;
      csr_bus.wr_data      = '0;
      alloc_pct            = 50;

      // model state after reset
      for (k = 0; k < NUM_CLASSES; k++) begin
         size_cfg[k]   = SIZE_W'(phase_size[0][k]);
         count_cfg[k]  = CNT_W'(phase_count[0][k]);
         cls_busy[k]   = '0;
         cls_allocs[k] = '0;
         cls_frees[k]  = '0;
         cls_peak[k]   = '0;
         for (n = 0; n < SLOTS_PER_CLASS; n++) begin
            pool_busy[k][n]  = 1'b0;
            pool_owner[k][n] = '0;
            pool_stamp[k][n] = '0;
         end
      end

      // late phases: sizes sometimes tiny so that classes collide
      for (p = 4; p < PHASES; p++) begin
         for (k = 0; k < NUM_CLASSES; k++) begin
            phase_size[p][k]  = $urandom_range(0, 1) ? $urandom_range(1, 8)
                                                    : $urandom_range(1, 65535);
            phase_count[p][k] = $urandom_range(0, 16);
         end
      end

      rows = '{
         // fresh pools: zero counters, bad class, undefined operation, unknown sizes
         '{req_word(FUNC_QUERY, 16'd0, 2'd0, 4'd0, 1'b1, 32'd0, 32'd0), 1'b1,
           pool_result(STAT_OK, 0, 0, 32'd0, 32'd0, 0, 32'd0, 32'd0, 0, 1'b0)},
         '{req_word(FUNC_QUERY, 16'd0, 2'd1, 4'd0, 1'b1, 32'd0, 32'd0), 1'b1,
           pool_result(STAT_OK, 0, 0, 32'd0, 32'd0, 0, 32'd0, 32'd0, 0, 1'b0)},
         '{req_word(FUNC_QUERY, 16'd0, CLASS_NONE, 4'd0, 1'b1, 32'd0, 32'd0), 1'b1,
           pool_result(STAT_BAD_HANDLE, 0, 0, 32'd0, 32'd0, 0, 32'd0, 32'd0, 0, 1'b0)},
         '{req_word(FUNC_UNDEF, 16'd100, 2'd0, 4'd0, 1'b1, 32'd0, 32'd0), 1'b1,
           pool_result(STAT_BAD_HANDLE, 0, 0, 32'd0, 32'd0, 0, 32'd0, 32'd0, 0, 1'b0)},
         '{req_word(FUNC_ALLOC, 16'd0, 2'd0, 4'd0, 1'b1, 32'd0, 32'd0), 1'b1,
           pool_result(STAT_UNKNOWN, 0, 0, 32'd0, 32'd0, 0, 32'd0, 32'd0, 0, 1'b0)},
         '{req_word(FUNC_ALLOC, 16'hFFFF, 2'd3, 4'hF, 1'b0, '1, '1), 1'b1,
           pool_result(STAT_UNKNOWN, 0, 0, 32'd0, 32'd0, 0, 32'd0, 32'd0, 0, 1'b0)},
         // two grants in class zero with extreme owner and time
         '{req_word(FUNC_ALLOC, 16'd100, 2'd0, 4'd0, 1'b1, 32'hFFFF_FFFF, 32'd0), 1'b1,
           pool_result(STAT_OK, 0, 0, 32'd0, 32'd0, 1, 32'd1, 32'd0, 1, 1'b0)},
         '{req_word(FUNC_ALLOC, 16'd100, 2'd0, 4'd0, 1'b1, 32'd0, 32'hFFFF_FFFF), 1'b1,
           pool_result(STAT_OK, 0, 1, 32'd0, 32'd0, 2, 32'd2, 32'd0, 2, 1'b0)},
         // broken guard, double free, index past the usable count, bad class
         '{req_word(FUNC_FREE, 16'd0, 2'd0, 4'd0, 1'b0, 32'd0, 32'd0), 1'b1,
           pool_result(STAT_OVERFLOW, 0, 0, 32'hFFFF_FFFF, 32'd0, 1, 32'd2, 32'd1, 2, 1'b0)},
         '{req_word(FUNC_FREE, 16'd0, 2'd0, 4'd0, 1'b1, 32'd0, 32'd0), 1'b1,
           pool_result(STAT_BAD_HANDLE, 0, 0, 32'd0, 32'd0, 1, 32'd2, 32'd1, 2, 1'b0)},
         '{req_word(FUNC_FREE, 16'd0, 2'd0, 4'hF, 1'b1, 32'd0, 32'd0), 1'b1,
           pool_result(STAT_BAD_HANDLE, 0, 0, 32'd0, 32'd0, 1, 32'd2, 32'd1, 2, 1'b0)},
         '{req_word(FUNC_FREE, 16'd0, CLASS_NONE, 4'd0, 1'b1, 32'd0, 32'd0), 1'b1,
           pool_result(STAT_BAD_HANDLE, 0, 0, 32'd0, 32'd0, 0, 32'd0, 32'd0, 0, 1'b0)},
         '{req_word(FUNC_FREE, 16'd0, 2'd0, 4'd1, 1'b0, 32'd0, 32'd0), 1'b1,
           pool_result(STAT_OVERFLOW, 0, 0, 32'd0, 32'hFFFF_FFFF, 0, 32'd2, 32'd2, 2, 1'b0)},
         // exhaust class one, then free and regrant a middle slot
         '{req_word(FUNC_ALLOC, 16'd500, 2'd0, 4'd0, 1'b1, 32'h0000_0011, 32'h10), 1'b0, '0},
         '{req_word(FUNC_ALLOC, 16'd500, 2'd0, 4'd0, 1'b1, 32'h0000_0012, 32'h20), 1'b0, '0},
         '{req_word(FUNC_ALLOC, 16'd500, 2'd0, 4'd0, 1'b1, 32'h0000_0013, 32'h30), 1'b0, '0},
         '{req_word(FUNC_ALLOC, 16'd500, 2'd0, 4'd0, 1'b1, 32'h0000_0014, 32'h40), 1'b0, '0},
         '{req_word(FUNC_ALLOC, 16'd500, 2'd0, 4'd0, 1'b1, 32'h0000_0015, 32'h50), 1'b0, '0},
         '{req_word(FUNC_ALLOC, 16'd500, 2'd0, 4'd0, 1'b1, 32'h0000_0016, 32'h60), 1'b0, '0},
         '{req_word(FUNC_FREE, 16'd0, 2'd1, 4'd2, 1'b1, 32'd0, 32'd0), 1'b0, '0},
         '{req_word(FUNC_ALLOC, 16'd500, 2'd0, 4'd0, 1'b1, 32'h0000_0017, 32'h70), 1'b0, '0},
         '{req_word(FUNC_QUERY, 16'd0, 2'd1, 4'd0, 1'b1, 32'd0, 32'd0), 1'b0, '0},
         '{req_word(FUNC_ALLOC, 16'd1000, 2'd0, 4'd0, 1'b1, 32'hA5A5_5A5A, 32'h1), 1'b0, '0},
         '{req_word(FUNC_FREE, 16'd0, 2'd2, 4'd4, 1'b1, 32'd0, 32'd0), 1'b0, '0}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (p = 0; p < PHASES; p++) begin
         if (p == 0) begin
            foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);
         end else begin
            // new class setting only with the pool idle
            wait_drained();
            for (k = 0; k < NUM_CLASSES; k++) begin
               write_csr(CSR_SIZE_BASE + k, phase_size[p][k]);
               write_csr(CSR_COUNT_BASE + k, phase_count[p][k]);
            end
         end
         for (n = 0; n < phase_items[p]; n++) begin
            if (n % 32 == 0) quiet_run = ($urandom_range(0, 3) == 0);
            if (n % 40 == 0) alloc_pct = $urandom_range(15, 70);
            make_random_word(alloc_pct, w);
            send_word(w, 1'b0, '0);
         end
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
